### sv/ansi_escape_key_event_fifo_macros.svh
// assertion macros for the escape-key event fifo
// expects clk and rst_n in the scope of each use
`ifndef ANSI_ESCAPE_KEY_EVENT_FIFO_MACROS_SVH
`define ANSI_ESCAPE_KEY_EVENT_FIFO_MACROS_SVH

// same-cycle implication
`define AKEF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AKEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/akef_pkg.sv
// types, codes and key tables shared by the escape-key event fifo
// no dependencies
`default_nettype none

package akef_pkg;

  localparam int OUT_COUNT_W = 7;

  localparam logic [1:0] ACT_INJECT = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_PEEK   = 2'd2;

  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] CHR_LBRACK = 8'h5B;
  localparam logic [7:0] CHR_TILDE  = 8'h7E;
  localparam logic [7:0] CHR_A      = 8'h41;
  localparam logic [7:0] CHR_B      = 8'h42;
  localparam logic [7:0] CHR_C      = 8'h43;
  localparam logic [7:0] CHR_D      = 8'h44;
  localparam logic [7:0] CHR_F      = 8'h46;
  localparam logic [7:0] CHR_H      = 8'h48;
  localparam logic [7:0] CHR_0      = 8'h30;
  localparam logic [7:0] CHR_1      = 8'h31;
  localparam logic [7:0] CHR_2      = 8'h32;
  localparam logic [7:0] CHR_3      = 8'h33;
  localparam logic [7:0] CHR_4      = 8'h34;
  localparam logic [7:0] CHR_5      = 8'h35;
  localparam logic [7:0] CHR_6      = 8'h36;
  localparam logic [7:0] CHR_7      = 8'h37;
  localparam logic [7:0] CHR_8      = 8'h38;
  localparam logic [7:0] CHR_9      = 8'h39;

  localparam logic [7:0] NAV_UP     = 8'd0;
  localparam logic [7:0] NAV_DOWN   = 8'd1;
  localparam logic [7:0] NAV_RIGHT  = 8'd2;
  localparam logic [7:0] NAV_LEFT   = 8'd3;
  localparam logic [7:0] NAV_HOME   = 8'd4;
  localparam logic [7:0] NAV_END    = 8'd5;
  localparam logic [7:0] NAV_INSERT = 8'd6;
  localparam logic [7:0] NAV_DELETE = 8'd7;
  localparam logic [7:0] NAV_PGUP   = 8'd8;
  localparam logic [7:0] NAV_PGDN   = 8'd9;

  localparam logic KIND_RAW = 1'b0;
  localparam logic KIND_NAV = 1'b1;

  typedef enum logic [1:0] {
    PS_IDLE,
    PS_ESC,
    PS_BRACKET,
    PS_DIGIT
  } parse_state_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_PUSH2,
    SQ_READ
  } seq_state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic                   event_valid;
    logic                   event_kind;
    logic [7:0]             event_code;
    logic [OUT_COUNT_W-1:0] queued_count;
  } out_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
  } event_t;

  typedef struct packed {
    logic   hit;
    logic [7:0] code;
  } nav_t;

  // events a parser step wants queued, first one then second one
  typedef struct packed {
    logic   push_a;
    event_t ev_a;
    logic   push_b;
    event_t ev_b;
  } parse_out_t;

  function automatic nav_t letter_nav(input logic [7:0] b);
    nav_t n;
    n.hit  = 1'b1;
    n.code = NAV_UP;
    case (b)
      CHR_A: n.code = NAV_UP;
      CHR_B: n.code = NAV_DOWN;
      CHR_C: n.code = NAV_RIGHT;
      CHR_D: n.code = NAV_LEFT;
      CHR_F: n.code = NAV_END;
      CHR_H: n.code = NAV_HOME;
      default: n.hit = 1'b0;
    endcase
    return n;
  endfunction

  function automatic nav_t digit_nav(input logic [7:0] d);
    nav_t n;
    n.hit  = 1'b1;
    n.code = NAV_HOME;
    case (d)
      CHR_1: n.code = NAV_HOME;
      CHR_2: n.code = NAV_INSERT;
      CHR_3: n.code = NAV_DELETE;
      CHR_4: n.code = NAV_END;
      CHR_5: n.code = NAV_PGUP;
      CHR_6: n.code = NAV_PGDN;
      CHR_7: n.code = NAV_HOME;
      CHR_8: n.code = NAV_END;
      default: n.hit = 1'b0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

### sv/ansi_escape_key_event_fifo.sv
// top level: request sequencer, queue pointers and result register
// depends on akef_pkg, akef_parser, akef_event_ram and the macros header
//
// Terminal bytes go in with action inject; pop and peek return the oldest
// key event. An item is taken when start is high and busy is low. An inject
// that queues at most one event ends in SQ_IDLE; one that queues a held ESC
// and its following byte also goes to SQ_PUSH2 to write the second event.
// A pop or peek answers from SQ_READ after reading the event memory when
// the queue holds events, and from SQ_IDLE when it is empty. Each result is
// shown for a single cycle under out_strobe, in the cycle after the last
// cycle of its item; the receiver cannot stall it, so it must take it then.
// Events that arrive with the queue full are dropped. Memory contents are
// not cleared at reset; only written entries are ever read.
`default_nettype none

`include "ansi_escape_key_event_fifo_macros.svh"

module ansi_escape_key_event_fifo #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire akef_pkg::in_item_t in_item,
  output logic                    out_strobe,
  output akef_pkg::out_item_t     out_item
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  akef_pkg::seq_state_t state_r, state_nxt;
  logic [AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 pop_r, pop_nxt;
  akef_pkg::event_t     pend_r, pend_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  akef_pkg::out_item_t  out_item_r, out_item_nxt;

  logic                 accept;
  logic                 full;
  logic                 parse_en;
  akef_pkg::parse_out_t pout;
  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  akef_pkg::event_t     mem_wr_data;
  logic                 mem_rd_en;
  akef_pkg::event_t     mem_rd_data;
  logic [CW-1:0]        count_after;

  assign busy     = (state_r != akef_pkg::SQ_IDLE);
  assign accept   = start && !busy;
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign parse_en = accept && (in_item.action == akef_pkg::ACT_INJECT);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  akef_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (parse_en),
    .byte_in (in_item.byte_in),
    .pout    (pout)
  );

  akef_event_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= akef_pkg::SQ_IDLE;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      count_r      <= '0;
      pop_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      count_r      <= count_nxt;
      pop_r        <= pop_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    count_nxt      = count_r;
    pop_nxt        = pop_r;
    pend_nxt       = pend_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = wr_ptr_r;
    mem_wr_data    = pout.ev_a;
    mem_rd_en      = 1'b0;
    count_after    = count_r;
    case (state_r)
      akef_pkg::SQ_IDLE: begin
        if (accept) begin
          case (in_item.action)
            akef_pkg::ACT_INJECT: begin
              if (pout.push_a && !full) begin
                mem_wr_en  = 1'b1;
                wr_ptr_nxt = ptr_inc(wr_ptr_r);
                count_nxt  = count_r + CW'(1);
              end
              if (pout.push_b) begin
                pend_nxt  = pout.ev_b;
                state_nxt = akef_pkg::SQ_PUSH2;
              end
            end
            akef_pkg::ACT_POP, akef_pkg::ACT_PEEK: begin
              if (count_r == '0) begin
                out_strobe_nxt = 1'b1;
                out_item_nxt   = '0;
              end else begin
                mem_rd_en = 1'b1;
                pop_nxt   = (in_item.action == akef_pkg::ACT_POP);
                state_nxt = akef_pkg::SQ_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      akef_pkg::SQ_PUSH2: begin
        mem_wr_data = pend_r;
        if (!full) begin
          mem_wr_en  = 1'b1;
          wr_ptr_nxt = ptr_inc(wr_ptr_r);
          count_nxt  = count_r + CW'(1);
        end
        state_nxt = akef_pkg::SQ_IDLE;
      end
      akef_pkg::SQ_READ: begin
        if (pop_r) begin
          count_after = count_r - CW'(1);
          rd_ptr_nxt  = ptr_inc(rd_ptr_r);
        end
        count_nxt                 = count_after;
        out_strobe_nxt            = 1'b1;
        out_item_nxt.event_valid  = 1'b1;
        out_item_nxt.event_kind   = mem_rd_data.kind;
        out_item_nxt.event_code   = mem_rd_data.code;
        out_item_nxt.queued_count = akef_pkg::OUT_COUNT_W'(count_after);
        state_nxt                 = akef_pkg::SQ_IDLE;
      end
      default: begin
        state_nxt = akef_pkg::SQ_IDLE;
      end
    endcase
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  `AKEF_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(QUEUE_DEPTH), "event count over depth")
  `AKEF_ASSERT_NEXT(a_read_result, state_r == akef_pkg::SQ_READ,
    out_strobe_r && out_item_r.event_valid, "read did not produce a valid item")
  `AKEF_ASSERT_NOW(a_no_write_on_read, state_r == akef_pkg::SQ_READ, !mem_wr_en,
    "memory write during read")
  `AKEF_ASSERT_NEXT(a_pop_count, state_r == akef_pkg::SQ_READ && pop_r,
    count_r == $past(count_r) - CW'(1), "pop did not lower count")
  `AKEF_ASSERT_NOW(a_empty_zero, out_strobe_r && !out_item_r.event_valid,
    out_item_r.queued_count == '0, "empty result with nonzero count")

endmodule

`default_nettype wire

### sv/akef_parser.sv
// escape-sequence parser: four-state machine plus held digit
// depends on akef_pkg
`default_nettype none

module akef_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire logic [7:0]         byte_in,
  output akef_pkg::parse_out_t    pout
);

  akef_pkg::parse_state_t state_r, state_nxt;
  logic [7:0]             held_digit_r, held_digit_nxt;
  akef_pkg::nav_t         nav;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= akef_pkg::PS_IDLE;
      held_digit_r <= '0;
    end else if (step_en) begin
      state_r      <= state_nxt;
      held_digit_r <= held_digit_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    held_digit_nxt = held_digit_r;
    pout           = '0;
    nav            = '0;
    case (state_r)
      akef_pkg::PS_IDLE: begin
        if (byte_in == akef_pkg::BYTE_ESC) begin
          state_nxt = akef_pkg::PS_ESC;
        end else begin
          pout.push_a = 1'b1;
          pout.ev_a   = {akef_pkg::KIND_RAW, byte_in};
        end
      end
      akef_pkg::PS_ESC: begin
        if (byte_in == akef_pkg::CHR_LBRACK) begin
          state_nxt = akef_pkg::PS_BRACKET;
        end else begin
          pout.push_a = 1'b1;
          pout.ev_a   = {akef_pkg::KIND_RAW, akef_pkg::BYTE_ESC};
          if (byte_in == akef_pkg::BYTE_ESC) begin
            state_nxt = akef_pkg::PS_ESC;
          end else begin
            state_nxt   = akef_pkg::PS_IDLE;
            pout.push_b = 1'b1;
            pout.ev_b   = {akef_pkg::KIND_RAW, byte_in};
          end
        end
      end
      akef_pkg::PS_BRACKET: begin
        if (byte_in >= akef_pkg::CHR_0 && byte_in <= akef_pkg::CHR_9) begin
          state_nxt      = akef_pkg::PS_DIGIT;
          held_digit_nxt = byte_in;
        end else begin
          state_nxt   = akef_pkg::PS_IDLE;
          nav         = akef_pkg::letter_nav(byte_in);
          pout.push_a = nav.hit;
          pout.ev_a   = {akef_pkg::KIND_NAV, nav.code};
        end
      end
      akef_pkg::PS_DIGIT: begin
        state_nxt = akef_pkg::PS_IDLE;
        if (byte_in == akef_pkg::CHR_TILDE) begin
          nav         = akef_pkg::digit_nav(held_digit_r);
          pout.push_a = nav.hit;
          pout.ev_a   = {akef_pkg::KIND_NAV, nav.code};
        end
      end
      default: begin
        state_nxt = akef_pkg::PS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/akef_event_ram.sv
// event store: one write port, one read port, registered read data
// depends on akef_pkg
`default_nettype none

module akef_event_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire akef_pkg::event_t wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output akef_pkg::event_t      rd_data
);

  akef_pkg::event_t store_mem [DEPTH];
  akef_pkg::event_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### test/tb_ansi_escape_key_event_fifo.sv
// testbench for ansi_escape_key_event_fifo: a directed table, then a random byte and request stream
// reads are checked against the directed table's expected item or an in-bench model of the parser and event queue
// depends on akef_pkg and the ansi_escape_key_event_fifo rtl
`default_nettype none

module tb_ansi_escape_key_event_fifo;
  import akef_pkg::*;

  localparam int QDEPTH = 64;
  localparam int TOTAL_ITEMS = 850;
  localparam int STALL_LIMIT = 1000;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [7:0] NO_KEY = 8'hFF;
  localparam out_item_t EMPTY_READ = '0;

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  // model state
  parse_state_t key_state = PS_IDLE;
  logic [7:0]   key_digit = '0;
  event_t       ev_ring [QDEPTH];
  int           ring_rd = 0;
  int           ring_wr = 0;
  int           ring_count = 0;

  out_item_t pending_reads [$];
  int n_items = 0;
  int n_reads = 0;
  int n_lost = 0;
  int n_errors = 0;
  int quiet_cycles = 0;
  int gap_pct = 0;

  ansi_escape_key_event_fifo #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] arrow_of_letter(input logic [7:0] ch);
    case (ch)
      CHR_A: return NAV_UP;
      CHR_B: return NAV_DOWN;
      CHR_C: return NAV_RIGHT;
      CHR_D: return NAV_LEFT;
      CHR_F: return NAV_END;
      CHR_H: return NAV_HOME;
      default: return NO_KEY;
    endcase
  endfunction

  function automatic logic [7:0] key_of_digit(input logic [7:0] ch);
    case (ch)
      CHR_1: return NAV_HOME;
      CHR_2: return NAV_INSERT;
      CHR_3: return NAV_DELETE;
      CHR_4: return NAV_END;
      CHR_5: return NAV_PGUP;
      CHR_6: return NAV_PGDN;
      CHR_7: return NAV_HOME;
      CHR_8: return NAV_END;
      default: return NO_KEY;
    endcase
  endfunction

  function automatic logic [7:0] pick_arrow_letter();
    case ($urandom_range(0, 5))
      0: return CHR_A;
      1: return CHR_B;
      2: return CHR_C;
      3: return CHR_D;
      4: return CHR_F;
      default: return CHR_H;
    endcase
  endfunction

  task automatic queue_event(input logic kind, input logic [7:0] code);
    if (ring_count >= QDEPTH) begin
      n_lost++;
    end else begin
      ev_ring[ring_wr] = {kind, code};
      ring_wr = (ring_wr + 1) % QDEPTH;
      ring_count++;
    end
  endtask

  task automatic key_decode(input logic [7:0] b);
    logic [7:0] nav;
    case (key_state)
      PS_IDLE: begin
        if (b == BYTE_ESC) key_state = PS_ESC;
        else queue_event(KIND_RAW, b);
      end
      PS_ESC: begin
        if (b == CHR_LBRACK) begin
          key_state = PS_BRACKET;
        end else begin
          // held escape was not a prefix
          queue_event(KIND_RAW, BYTE_ESC);
          if (b != BYTE_ESC) begin
            key_state = PS_IDLE;
            queue_event(KIND_RAW, b);
          end
        end
      end
      PS_BRACKET: begin
        if (b >= CHR_0 && b <= CHR_9) begin
          key_state = PS_DIGIT;
          key_digit = b;
        end else begin
          key_state = PS_IDLE;
          nav = arrow_of_letter(b);
          if (nav != NO_KEY) queue_event(KIND_NAV, nav);
        end
      end
      default: begin
        key_state = PS_IDLE;
        nav = key_of_digit(key_digit);
        if (b == CHR_TILDE && nav != NO_KEY) queue_event(KIND_NAV, nav);
      end
    endcase
  endtask

  task automatic apply_request(input in_item_t req, output logic has_read,
                               output out_item_t res);
    event_t head;
    has_read = 1'b0;
    res = EMPTY_READ;
    case (req.action)
      ACT_INJECT: begin
        key_decode(req.byte_in);
      end
      ACT_POP, ACT_PEEK: begin
        has_read = 1'b1;
        if (ring_count != 0) begin
          head = ev_ring[ring_rd];
          if (req.action == ACT_POP) begin
            ring_rd = (ring_rd + 1) % QDEPTH;
            ring_count--;
          end
          res = {1'b1, head.kind, head.code, OUT_COUNT_W'(ring_count)};
        end
      end
      default: ;
    endcase
  endtask

  // drive one item, wait for it to be taken, then log what it should return
  task automatic send_item(input in_item_t req, input logic typed, input out_item_t want);
    logic      has_read;
    out_item_t predicted;
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_request(req, has_read, predicted);
    if (has_read) pending_reads.push_back(typed ? want : predicted);
    if (req.action != ACT_NONE) n_items++;
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic inject(input logic [7:0] b);
    send_item({ACT_INJECT, b}, 1'b0, EMPTY_READ);
  endtask

  task automatic read_head(input logic [1:0] act);
    send_item({act, 8'($urandom_range(0, 255))}, 1'b0, EMPTY_READ);
  endtask

  task automatic wait_for_reads();
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // fill the queue to the brim, overflow it, then read it dry and past empty
  task automatic fill_and_drain();
    logic [7:0] b;
    while (ring_count < QDEPTH - 1) begin
      b = 8'($urandom_range(0, 255));
      if (b == BYTE_ESC) b = 8'h20;
      inject(b);
    end
    // escape pair with room for only the first
    inject(BYTE_ESC);
    inject(8'h61);
    repeat (3) inject(8'($urandom_range(0, 26)));
    inject(BYTE_ESC);
    inject(CHR_LBRACK);
    inject(CHR_B);
    while (ring_count > 0) read_head(($urandom_range(0, 3) != 0) ? ACT_POP : ACT_PEEK);
    read_head(ACT_POP);
    read_head(ACT_PEEK);
  endtask

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, field, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result, expected none got %h", $time, out_item);
        n_errors++;
      end else begin
        want = pending_reads.pop_front();
        n_reads++;
        check_field("event_valid", 8'(want.event_valid), 8'(out_item.event_valid));
        check_field("event_kind", 8'(want.event_kind), 8'(out_item.event_kind));
        check_field("event_code", want.event_code, out_item.event_code);
        check_field("queued_count", 8'(want.queued_count), 8'(out_item.queued_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    dir_row_t dir_rows [$];
    int       r;
    int       read_bias;
    bit       filled;
    bit       paused;
    filled  = 1'b0;
    paused  = 1'b0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty reads, undefined action, byte extremes and a peek of them
    dir_rows.push_back({ACT_POP, 8'h00, 1'b1, EMPTY_READ});
    dir_rows.push_back({ACT_PEEK, 8'hFF, 1'b1, EMPTY_READ});
    dir_rows.push_back({ACT_NONE, 8'hAA, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, 8'h00, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, 8'hFF, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_PEEK, 8'h55, 1'b1, {1'b1, KIND_RAW, 8'h00, 7'd2}});
    // arrow letter
    dir_rows.push_back({ACT_INJECT, BYTE_ESC, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, CHR_LBRACK, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, CHR_A, 1'b0, EMPTY_READ});
    // unmapped digit
    dir_rows.push_back({ACT_INJECT, BYTE_ESC, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, CHR_LBRACK, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, CHR_0, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, CHR_TILDE, 1'b0, EMPTY_READ});
    // unknown letter after bracket
    dir_rows.push_back({ACT_INJECT, BYTE_ESC, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, CHR_LBRACK, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, 8'h5A, 1'b0, EMPTY_READ});
    // digit without tilde
    dir_rows.push_back({ACT_INJECT, BYTE_ESC, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, CHR_LBRACK, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, CHR_3, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, 8'h71, 1'b0, EMPTY_READ});
    // escape, escape, plain byte
    dir_rows.push_back({ACT_INJECT, BYTE_ESC, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, BYTE_ESC, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_INJECT, 8'h78, 1'b0, EMPTY_READ});
    dir_rows.push_back({ACT_POP, 8'h00, 1'b1, {1'b1, KIND_RAW, 8'h00, 7'd5}});

    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    while (n_items < TOTAL_ITEMS) begin
      if (!filled && n_items >= 300) begin
        filled = 1'b1;
        fill_and_drain();
      end
      if (!paused && n_items >= 520) begin
        paused = 1'b1;
        wait_for_reads();
      end
      if (n_items >= TOTAL_ITEMS - 100) gap_pct = 0;
      else gap_pct = ((n_items / 64) % 3 == 0) ? 0 : 25;
      read_bias = (ring_count > 24) ? 60 : 40;
      r = $urandom_range(0, 99);
      if (r < read_bias) begin
        read_head(($urandom_range(0, 3) != 0) ? ACT_POP : ACT_PEEK);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          inject(BYTE_ESC);
          inject(CHR_LBRACK);
          inject(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : pick_arrow_letter());
        end else if (r < 60) begin
          inject(BYTE_ESC);
          inject(CHR_LBRACK);
          inject(CHR_0 + 8'($urandom_range(0, 9)));
          inject(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : CHR_TILDE);
        end else if (r < 72) begin
          inject(BYTE_ESC);
          inject(8'($urandom_range(0, 255)));
        end else if (r < 92) begin
          inject(8'($urandom_range(0, 255)));
        end else begin
          send_item({ACT_NONE, 8'($urandom_range(0, 255))}, 1'b0, EMPTY_READ);
        end
      end
    end

    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests sent, %0d reads checked, including full-queue overflow and empty reads",
             n_items, n_reads);
    $display("%0d events were lost to a full queue, %0d mismatches", n_lost, n_errors);
    if (n_errors == 0 && pending_reads.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
